FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the background fetch unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tbpf_pkg.sv
// ----------------------------------------------------------------------------
// tbpf_pkg
// Types, constants and codes shared by the background pixel fetch unit.
// ----------------------------------------------------------------------------
package tbpf_pkg;

	localparam int MEMORY_DEPTH_DEF = 16384;

	// Fixed field widths
	localparam int ADDR_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NT_SEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HALF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 2'd2;

	// Item kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Video memory map
	localparam logic [ADDR_W-1:0] NAME_BASE0 = 14'h2000;
	localparam logic [ADDR_W-1:0] NAME_BASE1 = 14'h2400;
	localparam logic [ADDR_W-1:0] ATTR_BASE0 = 14'h23c0;
	localparam logic [ADDR_W-1:0] ATTR_BASE1 = 14'h27c0;
	localparam logic [ADDR_W-1:0] PAL_BASE = 14'h3f00;
	localparam logic [ADDR_W-1:0] PAT_HALF_OFS = 14'h1000;
	// Palette mirror: entries 3f00/04/08/0c pair with 3f10/14/18/1c
	localparam logic [ADDR_W-1:0] MIRROR_MASK = 14'h3fe3;
	localparam logic [ADDR_W-1:0] MIRROR_BIT = 14'h0010;

	typedef struct packed {
		logic action;
		logic [13:0] mem_address;
		logic [7:0] write_byte;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic apply_scroll;
	} in_item_t;

	typedef struct packed {
		logic [1:0] palette_number;
		logic [1:0] color_number;
		logic [7:0] palette_byte;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MIRROR,
		ST_LO,
		ST_HI,
		ST_ATTR,
		ST_PAL,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_CLEAR,
		MOP_WRITE,
		MOP_MIRROR,
		MOP_NAME,
		MOP_LO,
		MOP_HI,
		MOP_ATTR,
		MOP_PAL
	} mem_op_t;

	typedef struct packed {
		mem_op_t op;
		logic capture;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic mirror_hit;
	} status_t;

endpackage

FILE: design/tbpf_ctrl.sv
// ----------------------------------------------------------------------------
// tbpf_ctrl
// Sequencer: clear pass, writes with palette mirror, five-step pixel fetch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbpf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_action,
	output logic               in_stall,
	input  logic               out_free,
	input  tbpf_pkg::status_t  status,
	output tbpf_pkg::cmd_t     cmd
);

	tbpf_pkg::state_t state_q, state_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbpf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = tbpf_pkg::MOP_NONE;
		cmd.capture = 1'b0;
		cmd.load_out = 1'b0;
		in_stall = 1'b1;
		accept = 1'b0;

		case (state_q)
			tbpf_pkg::ST_CLEAR: begin
				cmd.op = tbpf_pkg::MOP_CLEAR;
				if (status.clear_done) begin
					state_d = tbpf_pkg::ST_IDLE;
				end
			end
			tbpf_pkg::ST_IDLE, tbpf_pkg::ST_OUT: begin
				if (state_q == tbpf_pkg::ST_OUT) begin
					cmd.load_out = out_free;
					if (out_free) begin
						state_d = tbpf_pkg::ST_IDLE;
					end
				end
				in_stall = (state_q == tbpf_pkg::ST_OUT) && !out_free;
				accept = in_valid && !in_stall;
				if (accept) begin
					cmd.capture = 1'b1;
					if (in_action == tbpf_pkg::ACT_QUERY) begin
						cmd.op = tbpf_pkg::MOP_NAME;
						state_d = tbpf_pkg::ST_LO;
					end else begin
						cmd.op = tbpf_pkg::MOP_WRITE;
						state_d = status.mirror_hit ? tbpf_pkg::ST_MIRROR
							: tbpf_pkg::ST_IDLE;
					end
				end
			end
			tbpf_pkg::ST_MIRROR: begin
				cmd.op = tbpf_pkg::MOP_MIRROR;
				state_d = tbpf_pkg::ST_IDLE;
			end
			tbpf_pkg::ST_LO: begin
				cmd.op = tbpf_pkg::MOP_LO;
				state_d = tbpf_pkg::ST_HI;
			end
			tbpf_pkg::ST_HI: begin
				cmd.op = tbpf_pkg::MOP_HI;
				state_d = tbpf_pkg::ST_ATTR;
			end
			tbpf_pkg::ST_ATTR: begin
				cmd.op = tbpf_pkg::MOP_ATTR;
				state_d = tbpf_pkg::ST_PAL;
			end
			tbpf_pkg::ST_PAL: begin
				cmd.op = tbpf_pkg::MOP_PAL;
				state_d = tbpf_pkg::ST_OUT;
			end
			default: begin
				state_d = tbpf_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_rst_clear, clk, !arst_n |-> state_q == tbpf_pkg::ST_CLEAR, "reset must start the clear pass")
	`ASSERT_RST(a_query_seq, clk, arst_n, (accept && in_action == tbpf_pkg::ACT_QUERY) |=> state_q == tbpf_pkg::ST_LO, "query did not start fetch")
	`ASSERT_RST(a_pal_out, clk, arst_n, state_q == tbpf_pkg::ST_PAL |=> state_q == tbpf_pkg::ST_OUT, "palette read not followed by result")
	`ASSERT_RST(a_out_hold, clk, arst_n, (state_q == tbpf_pkg::ST_OUT && !out_free) |=> state_q == tbpf_pkg::ST_OUT, "result dropped while output full")

endmodule

FILE: design/tbpf_datapath.sv
// ----------------------------------------------------------------------------
// tbpf_datapath
// Config registers, video memory with its single port, and fetch registers.
// ----------------------------------------------------------------------------
module tbpf_datapath #(
	parameter int MEMORY_DEPTH = tbpf_pkg::MEMORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tbpf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  tbpf_pkg::in_item_t                   in_item,
	input  tbpf_pkg::cmd_t                       cmd,
	output tbpf_pkg::status_t                    status,
	output tbpf_pkg::out_item_t                  result
);

	localparam int AW = $clog2(MEMORY_DEPTH);

	logic [7:0] mem [MEMORY_DEPTH];

	logic [1:0] nt_sel_q;
	logic       pat_half_q;
	logic [7:0] scroll_q;
	logic [AW-1:0] clr_q;

	logic [7:0] rd_q;
	logic [13:0] waddr_q;
	logic [7:0] wbyte_q;
	logic [7:0] local_q;
	logic [7:0] py_q;
	logic       side_q;
	logic [7:0] tile_q;
	logic [7:0] lo_q;
	logic [7:0] hi_q;
	logic [1:0] pal_q;
	logic [1:0] color_q;

	logic [8:0] col;
	logic       side_in;
	logic [13:0] name_addr, pat_base, lo_addr, hi_addr, attr_addr, pal_addr;
	logic [2:0] bit_sel;
	logic [1:0] color_w, quad, pal_w;

	logic          mem_we;
	logic [AW-1:0] mem_a;
	logic [7:0]    mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_sel_q <= '0;
			pat_half_q <= 1'b0;
			scroll_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tbpf_pkg::CFG_NT_SEL: nt_sel_q <= cfg_data[1:0];
				tbpf_pkg::CFG_PAT_HALF: pat_half_q <= cfg_data[0];
				tbpf_pkg::CFG_SCROLL: scroll_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == tbpf_pkg::MOP_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign status.clear_done = (clr_q == AW'(MEMORY_DEPTH - 1));
	assign status.mirror_hit =
		(in_item.mem_address & tbpf_pkg::MIRROR_MASK) == tbpf_pkg::PAL_BASE;

	// column, screen half and table choice for an incoming query
	always_comb begin
		col = {1'b0, in_item.pixel_x}
			+ (in_item.apply_scroll ? {1'b0, scroll_q} : 9'd0);
		side_in = (nt_sel_q != 2'd0) != col[8];
		name_addr = (side_in ? tbpf_pkg::NAME_BASE1 : tbpf_pkg::NAME_BASE0)
			+ {4'd0, in_item.pixel_y[7:3], 5'd0} + {9'd0, col[7:3]};
	end

	always_comb begin
		pat_base = pat_half_q ? tbpf_pkg::PAT_HALF_OFS : 14'd0;
		lo_addr = pat_base + {2'd0, rd_q, 4'd0} + {11'd0, py_q[2:0]};
		hi_addr = pat_base + {2'd0, tile_q, 4'd0} + {10'd0, 1'b1, py_q[2:0]};
		attr_addr = (side_q ? tbpf_pkg::ATTR_BASE1 : tbpf_pkg::ATTR_BASE0)
			+ {8'd0, py_q[7:5], local_q[7:5]};
		bit_sel = 3'd7 - local_q[2:0];
		color_w = {hi_q[bit_sel], lo_q[bit_sel]};
		quad = {py_q[4], local_q[4]};
		pal_w = rd_q[{quad, 1'b0} +: 2];
		// colour zero shows the backdrop entry
		pal_addr = (color_w == 2'd0) ? tbpf_pkg::PAL_BASE
			: tbpf_pkg::PAL_BASE + {10'd0, pal_w, color_w};
	end

	always_comb begin
		mem_we = 1'b0;
		mem_a = '0;
		mem_wd = '0;
		case (cmd.op)
			tbpf_pkg::MOP_CLEAR: begin
				mem_we = 1'b1;
				mem_a = clr_q;
			end
			tbpf_pkg::MOP_WRITE: begin
				mem_we = 1'b1;
				mem_a = AW'(in_item.mem_address);
				mem_wd = in_item.write_byte;
			end
			tbpf_pkg::MOP_MIRROR: begin
				mem_we = 1'b1;
				mem_a = AW'(waddr_q ^ tbpf_pkg::MIRROR_BIT);
				mem_wd = wbyte_q;
			end
			tbpf_pkg::MOP_NAME: mem_a = AW'(name_addr);
			tbpf_pkg::MOP_LO: mem_a = AW'(lo_addr);
			tbpf_pkg::MOP_HI: mem_a = AW'(hi_addr);
			tbpf_pkg::MOP_ATTR: mem_a = AW'(attr_addr);
			tbpf_pkg::MOP_PAL: mem_a = AW'(pal_addr);
			default: ;
		endcase
	end

	// single port, read before write; read data holds when idle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_a] <= mem_wd;
		end
		if (cmd.op != tbpf_pkg::MOP_NONE) begin
			rd_q <= mem[mem_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			waddr_q <= in_item.mem_address;
			wbyte_q <= in_item.write_byte;
			local_q <= col[7:0];
			py_q <= in_item.pixel_y;
			side_q <= side_in;
		end
		case (cmd.op)
			tbpf_pkg::MOP_LO: tile_q <= rd_q;
			tbpf_pkg::MOP_HI: lo_q <= rd_q;
			tbpf_pkg::MOP_ATTR: hi_q <= rd_q;
			tbpf_pkg::MOP_PAL: begin
				pal_q <= pal_w;
				color_q <= color_w;
			end
			default: ;
		endcase
	end

	assign result.palette_number = pal_q;
	assign result.color_number = color_q;
	assign result.palette_byte = rd_q;

endmodule

FILE: design/tbpf_out_reg.sv
// ----------------------------------------------------------------------------
// tbpf_out_reg
// Output holding register between the fetch sequencer and the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbpf_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tbpf_pkg::out_item_t  d,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output tbpf_pkg::out_item_t  out_item
);

	logic valid_q;
	tbpf_pkg::out_item_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_item = data_q;

	`ASSERT_RST(a_load_shows, clk, arst_n, load |=> (out_valid && out_item == $past(d)), "loaded result not presented")

endmodule

FILE: design/tile_background_pixel_fetch_unit.sv
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch_unit
// Tile-map background pixel fetch over a byte-wide video memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / in_item): a write item stores
//    write_byte at mem_address (palette entries 3f00/04/08/0c and
//    3f10/14/18/1c are mirrored 0x10 apart); a query item returns one
//    result on the output channel (out_valid / out_stall / out_item).
//  - Config port: cfg_we with cfg_index 0 = name table select,
//    1 = pattern half, 2 = scroll x; other indexes are dropped.
//    Write config only while the unit is idle.
//  - Query steps: once a query is accepted, the name, low plane, high
//    plane, attribute and palette reads run in turn through the one
//    video memory port, and no new item is taken until they are done;
//    the result then loads into the output register, raising out_valid.
//    A write that hits a mirrored palette entry also writes its partner
//    before the next item is taken.
//  - Reset: the memory is swept to zero, one byte a cycle, over all
//    MEMORY_DEPTH bytes, with in_stall high; config writes are taken meanwhile.
//  - Receiver stall: a loaded result waits in the output register; items
//    are still taken, but a finished query waits with in_stall high until
//    the register is empty or being drained.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_unit #(
	parameter int MEMORY_DEPTH = tbpf_pkg::MEMORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbpf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tbpf_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tbpf_pkg::out_item_t              out_item
);

	tbpf_pkg::cmd_t cmd;
	tbpf_pkg::status_t status;
	tbpf_pkg::out_item_t result;
	logic out_free;

	// sequencer: owns the handshake and steps the fetch
	tbpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_item.action),
		.in_stall  (in_stall),
		.out_free  (out_free),
		.status    (status),
		.cmd       (cmd)
	);

	// memory, config registers and address generation
	tbpf_datapath #(
		.MEMORY_DEPTH (MEMORY_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// result register decouples the receiver from the sequencer
	tbpf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.load_out),
		.d         (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

FILE: sim/bg_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bg_pixel_checker
// Watches the config port and both item channels of the background fetch
// unit, keeps its own copy of video memory and registers, predicts each
// query result and compares it in order with what the unit returns.
// ----------------------------------------------------------------------------
module bg_pixel_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbpf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  tbpf_pkg::in_item_t               in_item,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  tbpf_pkg::out_item_t              out_item,
	output logic [31:0]                      mismatches,
	output logic [31:0]                      pending
);

	localparam int REPORT_MAX = 10;

	logic [7:0] vram [0:tbpf_pkg::MEMORY_DEPTH_DEF-1];
	logic [1:0] nt_sel;
	logic       pat_half;
	logic [7:0] scroll;
	tbpf_pkg::out_item_t pixel_expect_q [$];
	tbpf_pkg::out_item_t want;
	int         err_cnt;

	// Store a byte; the eight backdrop-slot palette entries pair up 0x10 apart.
	function automatic void vram_store(input logic [13:0] addr, input logic [7:0] data);
		vram[addr] = data;
		if ((addr & tbpf_pkg::MIRROR_MASK) == tbpf_pkg::PAL_BASE)
			vram[addr ^ tbpf_pkg::MIRROR_BIT] = data;
	endfunction

	function automatic tbpf_pkg::out_item_t fetch_bg_pixel(input tbpf_pkg::in_item_t q);
		logic [8:0]  col;
		logic [7:0]  loc_col, tile, lo, hi, attr;
		logic [2:0]  bit_sel;
		logic [1:0]  quad;
		logic        second;
		logic [13:0] name_base, attr_base, pat_row;
		tbpf_pkg::out_item_t r;
		col = {1'b0, q.pixel_x} + (q.apply_scroll ? {1'b0, scroll} : 9'd0);
		loc_col = col[7:0];
		// past column 255 the other table covers, unless the tables are swapped
		second = (nt_sel != 2'd0) != col[8];
		name_base = second ? tbpf_pkg::NAME_BASE1 : tbpf_pkg::NAME_BASE0;
		attr_base = second ? tbpf_pkg::ATTR_BASE1 : tbpf_pkg::ATTR_BASE0;
		tile = vram[name_base + {4'd0, q.pixel_y[7:3], 5'b0} + {9'd0, loc_col[7:3]}];
		pat_row = (pat_half ? tbpf_pkg::PAT_HALF_OFS : 14'h0) + {2'd0, tile, 4'b0}
			+ {11'd0, q.pixel_y[2:0]};
		lo = vram[pat_row];
		hi = vram[pat_row + 14'd8];
		bit_sel = 3'd7 - col[2:0];
		r.color_number = {hi[bit_sel], lo[bit_sel]};
		attr = vram[attr_base + {11'd0, loc_col[7:5]} + {8'd0, q.pixel_y[7:5], 3'b0}];
		quad = {q.pixel_y[4], col[4]};
		r.palette_number = attr[{quad, 1'b0} +: 2];
		r.palette_byte = (r.color_number == 2'd0) ? vram[tbpf_pkg::PAL_BASE] :
			vram[tbpf_pkg::PAL_BASE + {10'd0, r.palette_number, r.color_number}];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tbpf_pkg::MEMORY_DEPTH_DEF; i++)
				vram[i] = 8'h00;
			nt_sel = 2'd0;
			pat_half = 1'b0;
			scroll = 8'd0;
			pixel_expect_q.delete();
			err_cnt = 0;
			mismatches <= '0;
			pending <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tbpf_pkg::CFG_NT_SEL: nt_sel = cfg_data[1:0];
					tbpf_pkg::CFG_PAT_HALF: pat_half = cfg_data[0];
					tbpf_pkg::CFG_SCROLL: scroll = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pixel_expect_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("%0t: result with none pending: pal %0d color %0d byte %02h",
							$time, out_item.palette_number, out_item.color_number,
							out_item.palette_byte);
				end else begin
					want = pixel_expect_q.pop_front();
					if (out_item.palette_number !== want.palette_number ||
						out_item.color_number !== want.color_number ||
						out_item.palette_byte !== want.palette_byte) begin
						err_cnt++;
						if (err_cnt <= REPORT_MAX)
							$display("%0t: mismatch: exp pal %0d color %0d byte %02h, got pal %0d color %0d byte %02h",
								$time, want.palette_number, want.color_number,
								want.palette_byte, out_item.palette_number,
								out_item.color_number, out_item.palette_byte);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_item.action == tbpf_pkg::ACT_QUERY)
					pixel_expect_q.push_back(fetch_bg_pixel(in_item));
				else
					vram_store(in_item.mem_address, in_item.write_byte);
			end
			mismatches <= 32'(err_cnt);
			pending <= 32'(pixel_expect_q.size());
		end
	end

endmodule

FILE: sim/tile_background_pixel_fetch_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch_unit_test
// Drives writes and pixel queries into the fetch unit under a range of
// name table, pattern half and scroll settings, with random idling on both
// channels; the side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch_unit_test;

	localparam int SCENE_PHASE_ITEMS = 171;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 60000;    // covers the memory clear after reset
	localparam logic [tbpf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we = 1'b0;
	logic [tbpf_pkg::CFG_IDX_W-1:0]  cfg_index = tbpf_pkg::CFG_NT_SEL;
	logic [tbpf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	tbpf_pkg::in_item_t              in_item = '0;
	logic                            out_stall = 1'b0;
	logic                            in_stall;
	logic                            out_valid;
	tbpf_pkg::out_item_t             out_item;
	logic [31:0]                     mismatches;
	logic [31:0]                     pending;

	int   src_idle_pct = 0;
	int   rcv_idle_pct = 0;
	logic hold_req = 1'b0;    // toggled to start a long receiver hold-off
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   idle_cycles = 0;
	int   sent = 0;

	// Register values as last loaded; used only to aim scene setup writes.
	logic [1:0] cur_nt = 2'd0;
	logic       cur_ph = 1'b0;
	logic [7:0] cur_scroll = 8'd0;

	tile_background_pixel_fetch_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	bg_pixel_checker u_pixel_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stall, or a long hold-off once requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog: too long with nothing moving on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item, with a random gap first; returns at its accept edge.
	// in_stall is read right at the edge, so it is the pre-edge value.
	task automatic send_item(input tbpf_pkg::in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	// Write item; the query fields carry junk the unit must ignore.
	task automatic put_byte(input logic [13:0] addr, input logic [7:0] data);
		tbpf_pkg::in_item_t it;
		it.action = tbpf_pkg::ACT_WRITE;
		it.mem_address = addr;
		it.write_byte = data;
		it.pixel_x = 8'($urandom_range(255));
		it.pixel_y = 8'($urandom_range(255));
		it.apply_scroll = 1'($urandom_range(1));
		send_item(it);
	endtask

	// Query item; address and data are junk.
	task automatic ask_pixel(input logic [7:0] px, input logic [7:0] py, input logic scr);
		tbpf_pkg::in_item_t it;
		it.action = tbpf_pkg::ACT_QUERY;
		it.mem_address = 14'($urandom_range(16383));
		it.write_byte = 8'($urandom_range(255));
		it.pixel_x = px;
		it.pixel_y = py;
		it.apply_scroll = scr;
		send_item(it);
	endtask

	// Stop offering, wait out every pending result plus the tail of a write.
	// The first edge lets the pending count catch the last accepted item.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Write all three registers, then an index past the list with junk.
	task automatic load_config(input logic [1:0] nt, input logic ph, input logic [7:0] scr);
		cfg_we <= 1'b1;
		cfg_index <= tbpf_pkg::CFG_NT_SEL;
		cfg_data <= {6'b0, nt};
		@(posedge clk);
		cfg_index <= tbpf_pkg::CFG_PAT_HALF;
		cfg_data <= {7'b0, ph};
		@(posedge clk);
		cfg_index <= tbpf_pkg::CFG_SCROLL;
		cfg_data <= scr;
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= 8'($urandom_range(255));
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_nt = nt;
		cur_ph = ph;
		cur_scroll = scr;
	endtask

	// Set up one tile under a random pixel (name entry, both planes of its
	// row, attribute, a palette entry) and then query around it. Each setup
	// write is dropped now and then so some scenes stay half-built.
	task automatic tile_scene();
		logic [7:0]  px, py, loc_col, tile;
		logic [8:0]  col;
		logic [2:0]  jit;
		logic        scr, second;
		logic [13:0] nbase, abase, pat_row;
		int          n;
		px = 8'($urandom_range(255));
		py = 8'($urandom_range(255));
		scr = 1'($urandom_range(1));
		tile = 8'($urandom_range(255));
		col = {1'b0, px} + (scr ? {1'b0, cur_scroll} : 9'd0);
		loc_col = col[7:0];
		second = (cur_nt != 2'd0) != col[8];
		nbase = second ? tbpf_pkg::NAME_BASE1 : tbpf_pkg::NAME_BASE0;
		abase = second ? tbpf_pkg::ATTR_BASE1 : tbpf_pkg::ATTR_BASE0;
		pat_row = (cur_ph ? tbpf_pkg::PAT_HALF_OFS : 14'h0) + {2'd0, tile, 4'b0}
			+ {11'd0, py[2:0]};
		if ($urandom_range(99) >= 15)
			put_byte(nbase + {4'd0, py[7:3], 5'b0} + {9'd0, loc_col[7:3]}, tile);
		if ($urandom_range(99) >= 15)
			put_byte(pat_row, 8'($urandom_range(255)));
		if ($urandom_range(99) >= 15)
			put_byte(pat_row + 14'd8, 8'($urandom_range(255)));
		if ($urandom_range(99) >= 15)
			put_byte(abase + {11'd0, loc_col[7:5]} + {8'd0, py[7:5], 3'b0},
				8'($urandom_range(255)));
		if ($urandom_range(99) >= 15)
			put_byte(tbpf_pkg::PAL_BASE + 14'($urandom_range(31)), 8'($urandom_range(255)));
		n = $urandom_range(1, 4);
		repeat (n) begin
			jit = 3'($urandom_range(7));
			ask_pixel(px ^ {5'b0, jit}, py, scr);
		end
	endtask

	// Unshaped traffic: writes anywhere, mirrored palette slots, stray queries.
	task automatic noise_item();
		case ($urandom_range(3))
			0: put_byte(14'($urandom_range(16383)), 8'($urandom_range(255)));
			1: put_byte(tbpf_pkg::PAL_BASE + 14'(4 * $urandom_range(7)),
				8'($urandom_range(255)));
			default: ask_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
		endcase
	endtask

	initial begin : stimulus
		int         target;
		logic [1:0] nt;
		logic       ph;
		logic [7:0] scr;
		logic       held;
		held = 1'b0;
		arst_n <= 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		// Config is taken during the post-reset memory clear.
		load_config(2'd0, 1'b0, 8'd0);

		// Directed: cleared memory first, then palette mirroring both ways,
		// one known tile in the top-left corner, address and row extremes.
		ask_pixel(8'd0, 8'd0, 1'b0);
		put_byte(tbpf_pkg::PAL_BASE, 8'h0f);              // backdrop, mirrors up
		put_byte(tbpf_pkg::PAL_BASE + 14'h14, 8'h21);     // mirrors down
		put_byte(tbpf_pkg::PAL_BASE + 14'h18, 8'h32);
		put_byte(tbpf_pkg::PAL_BASE + 14'h0c, 8'h13);
		put_byte(tbpf_pkg::PAL_BASE + 14'h01, 8'h01);
		put_byte(tbpf_pkg::PAL_BASE + 14'h02, 8'h02);
		put_byte(tbpf_pkg::PAL_BASE + 14'h03, 8'h03);
		put_byte(tbpf_pkg::PAL_BASE + 14'h0f, 8'h3f);
		put_byte(tbpf_pkg::NAME_BASE0, 8'hff);            // tile 255 at top-left
		put_byte(14'h0ff0, 8'haa);                        // its low plane, row 0
		put_byte(14'h0ff8, 8'h55);                        // its high plane, row 0
		put_byte(tbpf_pkg::ATTR_BASE0, 8'he4);
		ask_pixel(8'd0, 8'd0, 1'b0);
		ask_pixel(8'd1, 8'd0, 1'b1);
		ask_pixel(8'd7, 8'd0, 1'b0);
		put_byte(14'h0000, 8'hff);
		put_byte(14'h3fff, 8'hff);
		ask_pixel(8'd255, 8'd239, 1'b0);
		ask_pixel(8'd255, 8'd255, 1'b1);        // row past the screen
		put_byte(tbpf_pkg::NAME_BASE1, 8'h10);
		put_byte(14'h0100, 8'hff);
		put_byte(14'h0108, 8'hff);
		put_byte(tbpf_pkg::ATTR_BASE1, 8'h1b);
		// Swapped tables: the left screen now reads the second table.
		drain_block();
		load_config(2'd1, 1'b0, 8'd0);
		ask_pixel(8'd0, 8'd0, 1'b0);
		ask_pixel(8'd31, 8'd17, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_block();
			case (p)
				0: begin
					nt = 2'd1; ph = 1'b1; scr = 8'd255;
				end
				1: begin
					nt = 2'd0; ph = 1'b0; scr = 8'd200;
				end
				2: begin
					nt = 2'd3; ph = 1'b1; scr = 8'd0;
				end
				3: begin
					nt = 2'd2; ph = 1'b0; scr = 8'd129;
				end
				4: begin
					nt = 2'd0; ph = 1'b1; scr = 8'd255;
				end
				default: begin
					nt = 2'($urandom_range(3));
					ph = 1'($urandom_range(1));
					scr = 8'($urandom_range(255));
				end
			endcase
			load_config(nt, ph, scr);
			// sender light / receiver heavy, then swapped, then no idling
			src_idle_pct = (p < 2) ? 9 : (p < 4) ? 54 : 0;
			rcv_idle_pct <= (p < 2) ? 54 : (p < 4) ? 9 : 0;
			target = sent + SCENE_PHASE_ITEMS;
			while (sent < target) begin
				// Long receiver hold-off while the sender keeps pushing.
				if (p == 4 && !held && sent >= target - SCENE_PHASE_ITEMS + 20) begin
					hold_req <= ~hold_req;
					held = 1'b1;
				end
				if ($urandom_range(99) < 70)
					tile_scene();
				else
					noise_item();
			end
		end

		drain_block();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
